// ===== rtl/rlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and codes of the ROM line cache.
// ----------------------------------------------------------------------------
package rlc_pkg;

   // width of the bank count register
   localparam int BANKS_BITS = 10;

   // opcodes as they arrive on the request side
   typedef enum logic [2:0] {
      OP_READ     = 3'd0,
      OP_PREFETCH = 3'd1,
      OP_PROBE    = 3'd2,
      OP_FILL     = 3'd3,
      OP_FAIL     = 3'd4
   } opcode_type;

   // classified item kinds carried through the queue
   typedef enum logic [2:0] {
      KIND_READ     = 3'd0,
      KIND_PREFETCH = 3'd1,
      KIND_PROBE    = 3'd2,
      KIND_FILL     = 3'd3,
      KIND_FAIL     = 3'd4,
      KIND_BAD      = 3'd5
   } kind_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_MISS    = 3'd1,
      ST_RANGE   = 3'd2,
      ST_FAIL    = 3'd3,
      ST_TAKEN   = 3'd4,
      ST_IGNORED = 3'd5
   } status_type;

   localparam logic [7:0] BYTE_NONE = 8'hFF;

endpackage

// ===== rtl/rlc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rlc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0]  store_ff [DEPTH];
   logic [PTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rptr_ff];

   // pointer and fill level
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // beat storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wptr_ff] <= wdata;
      end
   end
endmodule

// ===== rtl/rlc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_front
// Holds the ROM size, classifies request beats and queues them for the back.
// ----------------------------------------------------------------------------
module rlc_front #(
   parameter int BANK_BYTES = 16384,
   parameter int ADDR_BITS  = 23,
   parameter int ITEM_BITS  = 35
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rlc_pkg::BANKS_BITS-1:0]  csr_rom_banks,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [2:0]                      req_opcode,
   input  logic [ADDR_BITS-1:0]            req_addr,
   input  logic [7:0]                      req_fill_byte,
   input  logic                            q_pop,
   output logic [ITEM_BITS-1:0]            q_item,
   output logic                            q_empty
);
   import rlc_pkg::*;

   localparam int LIM_BITS = BANKS_BITS + $clog2(BANK_BYTES) + 1;
   localparam int CMP_BITS = (ADDR_BITS > LIM_BITS) ? ADDR_BITS : LIM_BITS;

   logic [LIM_BITS-1:0] limit_ff, limit_in;
   logic     in_range;
   kind_type kind;

   assign csr_ready = 1'b1;

   // ROM limit in bytes, worked out when the bank count is written
   assign limit_in = LIM_BITS'(csr_rom_banks) * LIM_BITS'(BANK_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIM_BITS'(2 * BANK_BYTES);
      end else if (csr_valid) begin
         limit_ff <= limit_in;
      end
   end

   // classify the beat
   assign in_range = CMP_BITS'(req_addr) < CMP_BITS'(limit_ff);

   always_comb begin
      unique case (req_opcode)
         OP_READ:     kind = KIND_READ;
         OP_PREFETCH: kind = KIND_PREFETCH;
         OP_PROBE:    kind = KIND_PROBE;
         OP_FILL:     kind = KIND_FILL;
         OP_FAIL:     kind = KIND_FAIL;
         default:     kind = KIND_BAD;
      endcase
   end

   rlc_fifo #(
      .WIDTH(ITEM_BITS),
      .DEPTH(2)
   ) u_req_q (
      .clock(clock),
      .reset(reset),
      .push (req_push),
      .wdata({kind, in_range, req_fill_byte, req_addr}),
      .full (req_full),
      .pop  (q_pop),
      .rdata(q_item),
      .empty(q_empty)
   );
endmodule

// ===== rtl/rlc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_back
// Sequencer that carries out one queued item: tag compare, LRU update,
// line fill and data memory access, then hands the result on.
// ----------------------------------------------------------------------------
module rlc_back #(
   parameter int LINE_BYTES = 64,
   parameter int NUM_SLOTS  = 16,
   parameter int ADDR_BITS  = 23,
   parameter int ITEM_BITS  = 35,
   parameter int RES_BITS   = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ITEM_BITS-1:0] q_item,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 res_push,
   output logic [RES_BITS-1:0]  res_data,
   input  logic                 res_full
);
   import rlc_pkg::*;

   localparam int SLOT_BITS = $clog2(NUM_SLOTS);
   localparam int OFF_BITS  = $clog2(LINE_BYTES);
   localparam int TAG_BITS  = ADDR_BITS - OFF_BITS;
   localparam int MEM_BITS  = SLOT_BITS + OFF_BITS;
   localparam int MEM_DEPTH = NUM_SLOTS * LINE_BYTES;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_MEM  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // item being worked on
   kind_type             kind_ff;
   logic                 rng_ff;
   logic [7:0]           fb_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [TAG_BITS-1:0]  item_tag;
   logic [OFF_BITS-1:0]  item_off;

   // cache directory
   logic [TAG_BITS-1:0]  tag_ff  [NUM_SLOTS];
   logic [SLOT_BITS-1:0] rank_ff [NUM_SLOTS];
   logic [SLOT_BITS-1:0] rank_in [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic                 tag_we;

   // pending fill
   logic                 pend_ff, pend_in;
   logic [SLOT_BITS-1:0] pslot_ff, pslot_in;
   logic [ADDR_BITS-1:0] paddr_ff, paddr_in;
   logic                 pread_ff, pread_in;
   logic [OFF_BITS-1:0]  foff_ff, foff_in;
   logic                 err_ff, err_in;

   // result being built
   status_type           st_ff, st_in;
   logic [7:0]           data_ff, data_in;
   logic                 pres_ff, pres_in;
   logic [ADDR_BITS-1:0] fetch_ff, fetch_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic                 use_mem_ff, use_mem_in;

   // data memory
   logic [7:0]           mem [MEM_DEPTH];
   logic [MEM_BITS-1:0]  rd_addr_ff, rd_addr_in;
   logic [7:0]           rdata_ff;
   logic                 mem_we;

   // lookup helpers
   logic                 hit, any_inv;
   logic [SLOT_BITS-1:0] hit_slot, inv_slot, lru_slot, victim;
   logic                 touch_en;
   logic [SLOT_BITS-1:0] touch_slot;

   assign item_tag = addr_ff[ADDR_BITS-1:OFF_BITS];
   assign item_off = addr_ff[OFF_BITS-1:0];
   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign res_push = (state_ff == S_OUT);
   assign res_data = {st_ff, (use_mem_ff ? rdata_ff : data_ff), pres_ff,
                      fetch_ff, slot_ff, err_ff};

   // parallel tag compare, first free slot and LRU slot
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      any_inv  = 1'b0;
      inv_slot = '0;
      lru_slot = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (valid_ff[i] && (tag_ff[i] == item_tag)) begin
            hit      = 1'b1;
            hit_slot = SLOT_BITS'(i);
         end
         if (rank_ff[i] == SLOT_BITS'(NUM_SLOTS-1)) begin
            lru_slot = SLOT_BITS'(i);
         end
      end
      for (int i = NUM_SLOTS-1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_inv  = 1'b1;
            inv_slot = SLOT_BITS'(i);
         end
      end
      victim = any_inv ? inv_slot : lru_slot;
   end

   // execute step
   always_comb begin
      valid_in   = valid_ff;
      pend_in    = pend_ff;
      pslot_in   = pslot_ff;
      paddr_in   = paddr_ff;
      pread_in   = pread_ff;
      foff_in    = foff_ff;
      err_in     = err_ff;
      st_in      = ST_IGNORED;
      data_in    = '0;
      pres_in    = 1'b0;
      fetch_in   = '0;
      slot_in    = '0;
      use_mem_in = 1'b0;
      rd_addr_in = rd_addr_ff;
      tag_we     = 1'b0;
      mem_we     = 1'b0;
      touch_en   = 1'b0;
      touch_slot = '0;
      case (kind_ff) inside
         KIND_READ, KIND_PREFETCH: begin
            if (pend_ff) begin
               st_in = ST_IGNORED;
            end else if (!rng_ff) begin
               st_in   = ST_RANGE;
               data_in = BYTE_NONE;
               if (kind_ff == KIND_PREFETCH) begin
                  err_in = 1'b1;
               end
            end else if (hit) begin
               st_in   = ST_DONE;
               pres_in = 1'b1;
               slot_in = hit_slot;
               if (kind_ff == KIND_READ) begin
                  touch_en   = 1'b1;
                  touch_slot = hit_slot;
                  use_mem_in = 1'b1;
                  rd_addr_in = {hit_slot, item_off};
               end
            end else begin
               valid_in[victim] = 1'b0;
               pend_in  = 1'b1;
               pslot_in = victim;
               paddr_in = addr_ff;
               pread_in = (kind_ff == KIND_READ);
               foff_in  = '0;
               st_in    = ST_MISS;
               fetch_in = {item_tag, {OFF_BITS{1'b0}}};
               slot_in  = victim;
            end
         end
         KIND_PROBE: begin
            if (!rng_ff) begin
               st_in = ST_RANGE;
            end else begin
               st_in = ST_DONE;
               if (hit) begin
                  pres_in = 1'b1;
                  slot_in = hit_slot;
               end
            end
         end
         KIND_FILL: begin
            if (pend_ff) begin
               mem_we  = 1'b1;
               slot_in = pslot_ff;
               if (foff_ff == OFF_BITS'(LINE_BYTES-1)) begin
                  tag_we             = 1'b1;
                  valid_in[pslot_ff] = 1'b1;
                  touch_en           = 1'b1;
                  touch_slot         = pslot_ff;
                  pend_in            = 1'b0;
                  foff_in            = '0;
                  st_in              = ST_DONE;
                  pres_in            = 1'b1;
                  if (pread_ff) begin
                     use_mem_in = 1'b1;
                     rd_addr_in = {pslot_ff, paddr_ff[OFF_BITS-1:0]};
                  end
               end else begin
                  foff_in = foff_ff + 1'b1;
                  st_in   = ST_TAKEN;
               end
            end
         end
         KIND_FAIL: begin
            if (pend_ff) begin
               slot_in = pslot_ff;
               pend_in = 1'b0;
               foff_in = '0;
               err_in  = 1'b1;
               st_in   = ST_FAIL;
               data_in = BYTE_NONE;
            end
         end
         default: begin
            st_in = ST_IGNORED;
         end
      endcase
   end

   // recency update: move one slot to the front
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         rank_in[i] = rank_ff[i];
         if (touch_en && (rank_ff[i] < rank_ff[touch_slot])) begin
            rank_in[i] = rank_ff[i] + 1'b1;
         end
      end
      if (touch_en) begin
         rank_in[touch_slot] = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (!q_empty) state_in = S_EXEC;
         S_EXEC: state_in = S_MEM;
         S_MEM:  state_in = S_OUT;
         S_OUT:  if (!res_full) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         pend_ff  <= 1'b0;
         pslot_ff <= '0;
         paddr_ff <= '0;
         pread_ff <= 1'b0;
         foff_ff  <= '0;
         err_ff   <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            rank_ff[i] <= SLOT_BITS'(i);
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == S_EXEC) begin
            valid_ff <= valid_in;
            pend_ff  <= pend_in;
            pslot_ff <= pslot_in;
            paddr_ff <= paddr_in;
            pread_ff <= pread_in;
            foff_ff  <= foff_in;
            err_ff   <= err_in;
            rank_ff  <= rank_in;
         end
      end
   end

   // item, result and tag payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff                   <= kind_type'(q_item[ITEM_BITS-1 -: 3]);
         {rng_ff, fb_ff, addr_ff}  <= q_item[ITEM_BITS-4:0];
      end
      if (state_ff == S_EXEC) begin
         st_ff      <= st_in;
         data_ff    <= data_in;
         pres_ff    <= pres_in;
         fetch_ff   <= fetch_in;
         slot_ff    <= slot_in;
         use_mem_ff <= use_mem_in;
         rd_addr_ff <= rd_addr_in;
         if (tag_we) begin
            tag_ff[pslot_ff] <= paddr_ff[ADDR_BITS-1:OFF_BITS];
         end
      end
   end

   // line data memory: fill write in the execute step, registered read after
   always_ff @(posedge clock) begin
      if ((state_ff == S_EXEC) && mem_we) begin
         mem[{pslot_ff, foff_ff}] <= fb_ff;
      end
      if (state_ff == S_MEM) begin
         rdata_ff <= mem[rd_addr_ff];
      end
   end
endmodule

// ===== rtl/rom_line_cache_lru.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_line_cache_lru
// Fully associative read-only line cache with LRU replacement in front of
// a ROM; request queue and classifier, execute sequencer, result queue.
// ----------------------------------------------------------------------------
// The execute sequencer works on one item at a time and pops the next only
// when idle; its steps are lookup with directory update, registered data
//   memory read and result hand-off, which waits while the result queue is full.
// Reset: synchronous; clears valid bits, pending fill and error flag, sets
//   recency to slot order and empties both queues. No clearing pass.
module rom_line_cache_lru #(
   parameter int LINE_BYTES = 64,
   parameter int NUM_SLOTS  = 16,
   parameter int BANK_BYTES = 16384,
   parameter int ADDR_BITS  = 23
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rlc_pkg::BANKS_BITS-1:0] csr_rom_banks,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [2:0]                     req_opcode,
   input  logic [ADDR_BITS-1:0]           req_addr,
   input  logic [7:0]                     req_fill_byte,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [2:0]                     rsp_status,
   output logic [7:0]                     rsp_read_data,
   output logic                           rsp_present,
   output logic [ADDR_BITS-1:0]           rsp_fetch_line_addr,
   output logic [$clog2(NUM_SLOTS)-1:0]   rsp_slot_used,
   output logic                           rsp_error_flag
);
   import rlc_pkg::*;

   localparam int SLOT_BITS = $clog2(NUM_SLOTS);
   localparam int ITEM_BITS = 3 + 1 + 8 + ADDR_BITS;
   localparam int RES_BITS  = 3 + 8 + 1 + ADDR_BITS + SLOT_BITS + 1;

   logic [ITEM_BITS-1:0] q_item;
   logic                 q_empty, q_pop;
   logic [RES_BITS-1:0]  res_data, rsp_data;
   logic                 res_push, res_full;

   rlc_front #(
      .BANK_BYTES(BANK_BYTES),
      .ADDR_BITS (ADDR_BITS),
      .ITEM_BITS (ITEM_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_rom_banks(csr_rom_banks),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_opcode   (req_opcode),
      .req_addr     (req_addr),
      .req_fill_byte(req_fill_byte),
      .q_pop        (q_pop),
      .q_item       (q_item),
      .q_empty      (q_empty)
   );

   rlc_back #(
      .LINE_BYTES(LINE_BYTES),
      .NUM_SLOTS (NUM_SLOTS),
      .ADDR_BITS (ADDR_BITS),
      .ITEM_BITS (ITEM_BITS),
      .RES_BITS  (RES_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_item  (q_item),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .res_push(res_push),
      .res_data(res_data),
      .res_full(res_full)
   );

   // result queue toward the consumer
   rlc_fifo #(
      .WIDTH(RES_BITS),
      .DEPTH(2)
   ) u_rsp_q (
      .clock(clock),
      .reset(reset),
      .push (res_push),
      .wdata(res_data),
      .full (res_full),
      .pop  (rsp_pop),
      .rdata(rsp_data),
      .empty(rsp_empty)
   );

   assign {rsp_status, rsp_read_data, rsp_present, rsp_fetch_line_addr,
           rsp_slot_used, rsp_error_flag} = rsp_data;
endmodule

// ===== verif/tb_rom_line_cache_lru.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rom_line_cache_lru
// Self-checking bench for the ROM line cache. A directed table of requests
// runs first, with some answers typed in; then random traffic follows, most
// of it well-formed miss/fill sequences. Every response beat is checked
// against a scoreboard fed by an in-bench cache predictor or a typed answer.
// ----------------------------------------------------------------------------
module tb_rom_line_cache_lru;
   import rlc_pkg::*;

   localparam int LINE_BYTES = 64;
   localparam int NUM_SLOTS  = 16;
   localparam int BANK_BYTES = 16384;
   localparam int ADDR_BITS  = 23;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [2:0]           status;
      logic [7:0]           read_data;
      logic                 present;
      logic [ADDR_BITS-1:0] fetch_line_addr;
      logic [3:0]           slot_used;
      logic                 error_flag;
   } rsp_beat_t;

   typedef struct {
      logic [2:0]           opcode;
      logic [ADDR_BITS-1:0] addr;
      logic [7:0]           fill_byte;
      bit                   typed;
      rsp_beat_t            answer;
   } stim_row_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [BANKS_BITS-1:0]   csr_rom_banks = '0;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic [2:0]              req_opcode = '0;
   logic [ADDR_BITS-1:0]    req_addr = '0;
   logic [7:0]              req_fill_byte = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic [2:0]              rsp_status;
   logic [7:0]              rsp_read_data;
   logic                    rsp_present;
   logic [ADDR_BITS-1:0]    rsp_fetch_line_addr;
   logic [3:0]              rsp_slot_used;
   logic                    rsp_error_flag;

   rom_line_cache_lru u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_rom_banks(csr_rom_banks),
      .req_push(req_push), .req_full(req_full), .req_opcode(req_opcode),
      .req_addr(req_addr), .req_fill_byte(req_fill_byte),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_status(rsp_status),
      .rsp_read_data(rsp_read_data), .rsp_present(rsp_present),
      .rsp_fetch_line_addr(rsp_fetch_line_addr), .rsp_slot_used(rsp_slot_used),
      .rsp_error_flag(rsp_error_flag)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [9:0]              rom_size_banks;
   logic [16:0]             slot_tag [NUM_SLOTS];
   bit                      slot_valid [NUM_SLOTS];
   logic [3:0]              slot_rank [NUM_SLOTS];
   logic [7:0]              slot_data [NUM_SLOTS*LINE_BYTES];
   bit                      fill_busy;
   logic [3:0]              fill_slot;
   logic [ADDR_BITS-1:0]    fill_addr;
   bit                      fill_for_read;
   int unsigned             fill_count;
   bit                      error_seen;

   rsp_beat_t               expected_rsps [$];
   int                      failures = 0;
   bit                      rx_idle_ok = 1'b1;
   bit                      tx_idle_ok = 1'b1;

   function automatic bit addr_in_rom(logic [ADDR_BITS-1:0] a);
      return longint'(a) < longint'(rom_size_banks) * BANK_BYTES;
   endfunction

   function automatic int lookup_slot(logic [16:0] tag);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_valid[i] && slot_tag[i] == tag) return i;
      return -1;
   endfunction

   function automatic void make_recent(int s);
      logic [3:0] r;
      r = slot_rank[s];
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_rank[i] < r) slot_rank[i]++;
      slot_rank[s] = '0;
   endfunction

   function automatic int pick_victim();
      int best;
      best = 0;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (!slot_valid[i]) return i;
      for (int i = 1; i < NUM_SLOTS; i++)
         if (slot_rank[i] > slot_rank[best]) best = i;
      return best;
   endfunction

   function automatic void cache_reset();
      rom_size_banks = 10'd2;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_rank[i] = 4'(i);
         slot_tag[i] = '0;
      end
      fill_busy = 1'b0;
      fill_slot = '0;
      fill_addr = '0;
      fill_for_read = 1'b0;
      fill_count = 0;
      error_seen = 1'b0;
   endfunction

   // compute the response to one request beat and advance the cache state
   function automatic rsp_beat_t cache_step(logic [2:0] op, logic [ADDR_BITS-1:0] a,
                                            logic [7:0] fb);
      rsp_beat_t r;
      logic [16:0] tag;
      int h;
      int v;
      r = '0;
      r.status = ST_IGNORED;
      tag = 17'(a / LINE_BYTES);
      case (op)
         OP_READ, OP_PREFETCH: begin
            if (fill_busy) begin
               r.status = ST_IGNORED;
            end else if (!addr_in_rom(a)) begin
               r.status = ST_RANGE;
               r.read_data = BYTE_NONE;
               if (op == OP_PREFETCH) error_seen = 1'b1;
            end else begin
               h = lookup_slot(tag);
               if (h >= 0) begin
                  r.status = ST_DONE;
                  r.present = 1'b1;
                  r.slot_used = 4'(h);
                  if (op == OP_READ) begin
                     make_recent(h);
                     r.read_data = slot_data[h*LINE_BYTES + a % LINE_BYTES];
                  end
               end else begin
                  v = pick_victim();
                  slot_valid[v] = 1'b0;
                  fill_busy = 1'b1;
                  fill_slot = 4'(v);
                  fill_addr = a;
                  fill_for_read = (op == OP_READ);
                  fill_count = 0;
                  r.status = ST_MISS;
                  r.fetch_line_addr = ADDR_BITS'(tag * LINE_BYTES);
                  r.slot_used = 4'(v);
               end
            end
         end
         OP_PROBE: begin
            if (!addr_in_rom(a)) begin
               r.status = ST_RANGE;
            end else begin
               h = lookup_slot(tag);
               r.status = ST_DONE;
               if (h >= 0) begin
                  r.present = 1'b1;
                  r.slot_used = 4'(h);
               end
            end
         end
         OP_FILL: begin
            if (fill_busy) begin
               slot_data[fill_slot*LINE_BYTES + fill_count] = fb;
               fill_count++;
               r.slot_used = fill_slot;
               if (fill_count >= LINE_BYTES) begin
                  slot_tag[fill_slot] = 17'(fill_addr / LINE_BYTES);
                  slot_valid[fill_slot] = 1'b1;
                  make_recent(fill_slot);
                  fill_busy = 1'b0;
                  fill_count = 0;
                  r.status = ST_DONE;
                  r.present = 1'b1;
                  if (fill_for_read)
                     r.read_data = slot_data[fill_slot*LINE_BYTES + fill_addr % LINE_BYTES];
               end else begin
                  r.status = ST_TAKEN;
               end
            end
         end
         OP_FAIL: begin
            if (fill_busy) begin
               r.slot_used = fill_slot;
               fill_busy = 1'b0;
               fill_count = 0;
               error_seen = 1'b1;
               r.status = ST_FAIL;
               r.read_data = BYTE_NONE;
            end
         end
         default: ;
      endcase
      r.error_flag = error_seen;
      return r;
   endfunction

   // push one request beat; a typed answer replaces the prediction as expectation
   task automatic send_req(logic [2:0] op, logic [ADDR_BITS-1:0] a, logic [7:0] fb,
                           bit typed = 1'b0, rsp_beat_t answer = '0);
      rsp_beat_t p;
      while (tx_idle_ok && $urandom_range(99) < 24) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_opcode <= op;
      req_addr <= a;
      req_fill_byte <= fb;
      @(posedge clock);
      while (req_full) @(posedge clock);
      p = cache_step(op, a, fb);
      expected_rsps.push_back(typed ? answer : p);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_banks(logic [9:0] value);
      csr_valid <= 1'b1;
      csr_rom_banks <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      rom_size_banks = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // miss/fill sequence with random line content, now and then cut short by a fail
   task automatic line_sequence(logic [ADDR_BITS-1:0] a, bit as_read);
      send_req(as_read ? OP_READ : OP_PREFETCH, a, 8'($urandom));
      if (!fill_busy) return;
      if ($urandom_range(19) == 0) begin
         repeat ($urandom_range(LINE_BYTES - 1))
            send_req(OP_FILL, ADDR_BITS'($urandom), 8'($urandom));
         send_req(OP_FAIL, ADDR_BITS'($urandom), 8'($urandom));
      end else begin
         while (fill_busy) begin
            if ($urandom_range(15) == 0)
               send_req(3'($urandom_range(2)), ADDR_BITS'($urandom), 8'($urandom));
            else
               send_req(OP_FILL, ADDR_BITS'($urandom), 8'($urandom));
         end
      end
   endtask

   // response side: random pops, compare with oldest expectation
   always @(negedge clock) begin
      rsp_pop <= !(rx_idle_ok && $urandom_range(99) < 24);
   end

   always @(posedge clock) begin
      rsp_beat_t got;
      rsp_beat_t want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_status, rsp_read_data, rsp_present, rsp_fetch_line_addr,
                 rsp_slot_used, rsp_error_flag};
         if (expected_rsps.size() == 0) begin
            $error("response beat with nothing expected: %h", got);
            failures++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, got.status);
               failures++;
            end
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
               failures++;
            end
            if (got.present !== want.present) begin
               $error("present: expected %0d, actual %0d", want.present, got.present);
               failures++;
            end
            if (got.fetch_line_addr !== want.fetch_line_addr) begin
               $error("fetch_line_addr: expected %h, actual %h",
                      want.fetch_line_addr, got.fetch_line_addr);
               failures++;
            end
            if (got.slot_used !== want.slot_used) begin
               $error("slot_used: expected %0d, actual %0d", want.slot_used, got.slot_used);
               failures++;
            end
            if (got.error_flag !== want.error_flag) begin
               $error("error_flag: expected %0d, actual %0d",
                      want.error_flag, got.error_flag);
               failures++;
            end
         end
      end
   end

   // run limit
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rom_line_cache_lru test failed");
         $finish;
      end
   end

   function automatic rsp_beat_t beat(logic [2:0] st, logic [7:0] d, logic p,
                                      logic [ADDR_BITS-1:0] f, logic [3:0] s, logic e);
      rsp_beat_t r;
      r = '{st, d, p, f, s, e};
      return r;
   endfunction

   stim_row_t directed [$];
   logic [ADDR_BITS-1:0] top_addr;

   initial begin
      logic [9:0] bank_set;
      logic [ADDR_BITS-1:0] a;
      int hot_lines;
      cache_reset();
      top_addr = '1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table: typed answers after reset and at the extremes
      directed = '{
         '{OP_PROBE, 23'd0, 8'h00, 1'b1, beat(ST_DONE, 8'h00, 1'b0, 23'd0, 4'd0, 1'b0)},
         '{OP_FILL, 23'd0, 8'hFF, 1'b1, beat(ST_IGNORED, 8'h00, 1'b0, 23'd0, 4'd0, 1'b0)},
         '{OP_FAIL, 23'd0, 8'h00, 1'b1, beat(ST_IGNORED, 8'h00, 1'b0, 23'd0, 4'd0, 1'b0)},
         '{3'd5, 23'h7FFFFF, 8'hFF, 1'b1,
           beat(ST_IGNORED, 8'h00, 1'b0, 23'd0, 4'd0, 1'b0)},
         '{3'd7, 23'h2AAAAA, 8'h55, 1'b1,
           beat(ST_IGNORED, 8'h00, 1'b0, 23'd0, 4'd0, 1'b0)},
         '{OP_READ, 23'h7FFFFF, 8'h00, 1'b1,
           beat(ST_RANGE, 8'hFF, 1'b0, 23'd0, 4'd0, 1'b0)},
         '{OP_PROBE, 23'd32768, 8'h00, 1'b1,
           beat(ST_RANGE, 8'h00, 1'b0, 23'd0, 4'd0, 1'b0)},
         '{OP_PREFETCH, 23'd0, 8'h00, 1'b1,
           beat(ST_MISS, 8'h00, 1'b0, 23'd0, 4'd0, 1'b0)},
         '{OP_READ, 23'd5, 8'h00, 1'b1, beat(ST_IGNORED, 8'h00, 1'b0, 23'd0, 4'd0, 1'b0)},
         '{OP_PROBE, 23'd5, 8'h00, 1'b0, '0},
         '{OP_FAIL, 23'd0, 8'h00, 1'b1, beat(ST_FAIL, 8'hFF, 1'b0, 23'd0, 4'd0, 1'b1)},
         '{OP_PREFETCH, 23'd32767, 8'h00, 1'b1,
           beat(ST_MISS, 8'h00, 1'b0, 23'd32704, 4'd0, 1'b1)},
         '{OP_FAIL, 23'd0, 8'h00, 1'b0, '0},
         '{OP_PREFETCH, 23'd32768, 8'h00, 1'b1,
           beat(ST_RANGE, 8'hFF, 1'b0, 23'd0, 4'd0, 1'b1)}
      };
      foreach (directed[i])
         send_req(directed[i].opcode, directed[i].addr, directed[i].fill_byte,
                  directed[i].typed, directed[i].answer);
      // a read miss and its fill sequence, then a read and a prefetch of that line
      line_sequence(23'd32767, 1'b1);
      send_req(OP_READ, 23'd32767, 8'h00);
      send_req(OP_PREFETCH, 23'd32704, 8'h00);

      // phases over bank settings; the sender pauses until drained each time
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: bank_set = 10'd512;
            1: bank_set = 10'd0;
            2: bank_set = 10'd1;
            3: bank_set = 10'h3FF;
            4: bank_set = 10'($urandom_range(2, 511));
            default: bank_set = 10'd2;
         endcase
         write_banks(bank_set);
         tx_idle_ok = (phase != 2);
         rx_idle_ok = (phase != 2);
         // keep a small working set of lines so hits and LRU evictions both occur
         hot_lines = $urandom_range(12, 24);
         for (int n = 0; n < 8; n++) begin
            if ($urandom_range(9) < 7) begin
               a = ADDR_BITS'($urandom_range(hot_lines - 1) * LINE_BYTES
                              + $urandom_range(LINE_BYTES - 1));
               if ($urandom_range(15) == 0) a = ADDR_BITS'($urandom);
               if ($urandom_range(31) == 0) a = top_addr;
               line_sequence(a, $urandom_range(3) != 0);
               repeat ($urandom_range(3))
                  send_req(3'($urandom_range(2)), ADDR_BITS'($urandom_range(hot_lines - 1)
                           * LINE_BYTES + $urandom_range(LINE_BYTES - 1)), 8'($urandom));
            end else begin
               send_req(3'($urandom), ADDR_BITS'($urandom), 8'($urandom));
            end
         end
      end

      wait_drained();
      if (failures == 0) begin
         $display("rom_line_cache_lru test passed");
      end else begin
         $display("rom_line_cache_lru test failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/rlc_pkg.sv
rtl/rlc_fifo.sv
rtl/rlc_front.sv
rtl/rlc_back.sv
rtl/rom_line_cache_lru.sv
verif/tb_rom_line_cache_lru.sv
